FILE: src/packed_bit_vector_store_macros.svh
// ----------------------------------------------------------------------------
// packed_bit_vector_store_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PACKED_BIT_VECTOR_STORE_MACROS_SVH
`define PACKED_BIT_VECTOR_STORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PBVS_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PBVS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

FILE: src/pbvs_pkg.sv
// ----------------------------------------------------------------------------
// pbvs_pkg
// Shared types and constants for the packed bit vector store.
// ----------------------------------------------------------------------------
package pbvs_pkg;

   localparam int CAPACITY_DEF = 256;

   localparam int OP_W  = 3;
   localparam int IDX_W = 9;
   localparam int LEN_W = 9;
   localparam int ST_W  = 2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
   localparam logic [OP_W-1:0] OP_GET    = 3'd1;
   localparam logic [OP_W-1:0] OP_SET    = 3'd2;
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
   localparam logic [OP_W-1:0] OP_ERASE  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

   // Command broadcast from the control unit to every cell.
   typedef struct packed {
      logic clear;       // zero the cell
      logic write;       // write value at the target position
      logic shift_up;    // insert: positions above target take their lower neighbor
      logic shift_down;  // erase: positions at or above target take their upper neighbor
      logic value;       // bit written at the target position
   } cell_cmd_type;

endpackage

FILE: src/pbvs_cell.sv
// ----------------------------------------------------------------------------
// pbvs_cell
// One bit of the store. Compares its own position against the broadcast
// target and clears, takes the value, its lower neighbor or its upper neighbor.
// ----------------------------------------------------------------------------
module pbvs_cell #(
   parameter int POS   = 0,
   parameter int CMP_W = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pbvs_pkg::cell_cmd_type cmd,
   input  logic [CMP_W-1:0]      target,
   input  logic                  below_bit,
   input  logic                  above_bit,
   output logic                  bit_out,
   output logic                  hit_out
);
   import pbvs_pkg::*;

   localparam logic [CMP_W-1:0] POS_C = CMP_W'(POS);

   logic bit_ff;
   logic bit_in;
   logic at_target;
   logic past_target;

   assign at_target   = (POS_C == target);
   assign past_target = (POS_C > target);

   always_comb begin
      bit_in = bit_ff;
      if (cmd.clear) begin
         bit_in = 1'b0;
      end else if (cmd.write) begin
         if (at_target) begin
            bit_in = cmd.value;
         end
      end else if (cmd.shift_up) begin
         if (past_target) begin
            bit_in = below_bit;
         end else if (at_target) begin
            bit_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (past_target || at_target) begin
            bit_in = above_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_out = bit_ff;
   assign hit_out = bit_ff & at_target;

endmodule

FILE: src/pbvs_ctrl.sv
// ----------------------------------------------------------------------------
// pbvs_ctrl
// Length register and request decode: checks each request, builds the
// command for the cell row and the status and length of the response.
// ----------------------------------------------------------------------------
module pbvs_ctrl #(
   parameter int CAPACITY = pbvs_pkg::CAPACITY_DEF,
   parameter int CNT_W    = 9,
   parameter int CMP_W    = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [pbvs_pkg::OP_W-1:0]  op,
   input  logic [pbvs_pkg::IDX_W-1:0] bit_index,
   input  logic                   bit_value,
   output pbvs_pkg::cell_cmd_type cmd,
   output logic [CMP_W-1:0]       target,
   output logic                   read_en,
   output logic [pbvs_pkg::LEN_W-1:0] length_next,
   output logic [pbvs_pkg::ST_W-1:0]  status
);
   import pbvs_pkg::*;

   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [CMP_W-1:0] CAP_E = CMP_W'(CAPACITY);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] idx_e;
   logic [CMP_W-1:0] cnt_e;
   logic [CMP_W-1:0] next_e;
   logic             full;
   cell_cmd_type     cmd_raw;
   logic             read_raw;

   assign idx_e = CMP_W'(bit_index);
   assign cnt_e = CMP_W'(count_ff);
   assign full  = (count_ff == CAP_C);

   always_comb begin
      cmd_raw       = '0;
      cmd_raw.value = bit_value;
      read_raw      = 1'b0;
      target        = idx_e;
      count_in      = count_ff;
      status        = ST_OK;
      case (op)
         OP_INIT: begin
            if (idx_e == '0 || idx_e > CAP_E) begin
               status = ST_RANGE;
            end else begin
               cmd_raw.clear = 1'b1;
               count_in      = CNT_W'(idx_e);
            end
         end
         OP_GET: begin
            if (idx_e >= cnt_e) begin
               status = ST_RANGE;
            end else begin
               read_raw = 1'b1;
            end
         end
         OP_SET: begin
            if (idx_e >= cnt_e) begin
               status = ST_RANGE;
            end else begin
               cmd_raw.write = 1'b1;
            end
         end
         OP_PUSH: begin
            target = cnt_e;
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd_raw.write = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         OP_INSERT: begin
            if (idx_e > cnt_e) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cmd_raw.shift_up = 1'b1;
               count_in         = count_ff + CNT_W'(1);
            end
         end
         OP_ERASE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (idx_e >= cnt_e) begin
               status = ST_RANGE;
            end else begin
               cmd_raw.shift_down = 1'b1;
               count_in           = count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Drive the cell row only on an accepted request.
   always_comb begin
      cmd            = cmd_raw;
      cmd.clear      = cmd_raw.clear & accept;
      cmd.write      = cmd_raw.write & accept;
      cmd.shift_up   = cmd_raw.shift_up & accept;
      cmd.shift_down = cmd_raw.shift_down & accept;
   end

   assign read_en     = read_raw;
   assign next_e      = CMP_W'(count_in);
   assign length_next = next_e[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/packed_bit_vector_store.sv
// ----------------------------------------------------------------------------
// packed_bit_vector_store
// Bounded dynamic bit vector with get, set, push back, insert and erase.
// ----------------------------------------------------------------------------
// The store is a row of CAPACITY one-bit cells. Every request is decoded
// combinationally into a command that is broadcast along the row; each cell
// compares its own position against the target (the request index, or the
// length for a push) and either holds, clears (init), takes the request bit,
// takes its lower neighbor (insert) or takes its upper neighbor (erase), so
// an insert or erase moves the whole tail of the vector by one place at once.
// A get reads through a per-cell hit term OR-ed across the row. The response is
// registered on acceptance and shows on rsp_tvalid the next cycle, and a new
// request is taken in the same cycle as the previous response is taken, so
// the sustained rate is one request per clock while rsp_tready stays high.
// Failed requests (index out of range, full, empty) leave the store and the
// length untouched and report their status. Reset clears every cell and the
// length at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module packed_bit_vector_store #(
   parameter int CAPACITY = pbvs_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: op[2:0], bit_index[11:3], bit_value[12], zero pad [15:13]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pbvs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: read_bit[0], length[9:1], status[11:10], zero pad [15:12]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pbvs_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import pbvs_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int RSP_USED = 1 + LEN_W + ST_W;

   // Unpack the request.
   logic [OP_W-1:0]  op;
   logic [IDX_W-1:0] bit_index;
   logic             bit_value;

   assign op        = req_tdata[OP_W-1:0];
   assign bit_index = req_tdata[OP_W +: IDX_W];
   assign bit_value = req_tdata[OP_W + IDX_W];

   logic accept;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   // Take a request whenever the output register is empty or drains now.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   cell_cmd_type     cmd;
   logic [CMP_W-1:0] target;
   logic             read_en;
   logic [LEN_W-1:0] length_next;
   logic [ST_W-1:0]  status;

   pbvs_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .CMP_W    (CMP_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (op),
      .bit_index   (bit_index),
      .bit_value   (bit_value),
      .cmd         (cmd),
      .target      (target),
      .read_en     (read_en),
      .length_next (length_next),
      .status      (status)
   );

   // Cell row: each cell sees its lower and upper neighbor; the ends see zero.
   logic [CAPACITY-1:0] store_bit;
   logic [CAPACITY-1:0] hit;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic below;
      logic above;
      if (i == 0) begin : g_lo
         assign below = 1'b0;
      end else begin : g_lo
         assign below = store_bit[i-1];
      end
      if (i == CAPACITY - 1) begin : g_hi
         assign above = 1'b0;
      end else begin : g_hi
         assign above = store_bit[i+1];
      end
      pbvs_cell #(
         .POS   (i),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .target    (target),
         .below_bit (below),
         .above_bit (above),
         .bit_out   (store_bit[i]),
         .hit_out   (hit[i])
      );
   end

   logic read_bit;
   assign read_bit = read_en & (|hit);

   // Hold the response until taken; load a new one on every accepted request.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(RSP_DATA_W - RSP_USED)'(0), status, length_next, read_bit};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/pbvs_checker.sv
// ----------------------------------------------------------------------------
// pbvs_checker
// Port-level checks for the packed bit vector store, bound to the top level.
// ----------------------------------------------------------------------------
`include "packed_bit_vector_store_macros.svh"

module pbvs_checker #(
   parameter int CAPACITY = pbvs_pkg::CAPACITY_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [pbvs_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pbvs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pbvs_pkg::*;

   logic             req_fire;
   logic             rsp_stall;
   logic [LEN_W-1:0] rsp_len;
   logic [ST_W-1:0]  rsp_status;

   assign req_fire   = req_tvalid & req_tready;
   assign rsp_stall  = rsp_tvalid & ~rsp_tready;
   assign rsp_len    = rsp_tdata[LEN_W:1];
   assign rsp_status = rsp_tdata[LEN_W + ST_W:LEN_W + 1];

   `PBVS_ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_fire, rsp_tvalid, "no response after request")

   `PBVS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_tdata) && rsp_tvalid, "stalled response changed")

   `PBVS_ASSERT_NOW(a_len_bound, clock, reset, rsp_tvalid, (CAPACITY > 511) || (rsp_len <= LEN_W'(CAPACITY)), "length above capacity")

   `PBVS_ASSERT_NOW(a_fail_no_read, clock, reset, rsp_tvalid && (rsp_status != ST_OK), rsp_tdata[0] == 1'b0, "read bit set on failed request")

endmodule

bind packed_bit_vector_store pbvs_checker #(.CAPACITY(CAPACITY)) u_pbvs_checker (.*);
